@@ src/two_stage_autorepeat_timer_macros.svh @@
// Assertion macros for the two-stage autorepeat timer.
// Included by the modules that check their own logic; needs clk and rst_n in scope.
`ifndef TWO_STAGE_AUTOREPEAT_TIMER_MACROS_SVH
`define TWO_STAGE_AUTOREPEAT_TIMER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ATR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define ATR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/atr_pkg.sv @@
// Shared types, constants and helpers for the two-stage autorepeat timer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package atr_pkg;

  localparam int TIME_WIDTH  = 32;  // width of the held and since-fire accumulators
  localparam int STAMP_W     = 32;  // timestamp width, differences wrap at this width
  localparam int CFG_W       = 16;
  localparam int VAL_W       = 16;
  localparam int PHASE_W     = 2;
  localparam int IDX_W       = 2;
  localparam int SUM_W       = ((TIME_WIDTH > STAMP_W) ? TIME_WIDTH : STAMP_W) + 1;
  localparam int IN_TDATA_W  = ((STAMP_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + PHASE_W + 7) / 8) * 8;

  typedef enum logic [PHASE_W-1:0] {
    PH_START  = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_FIRST_DELAY   = 2'd0,
    CFG_FIRST_PERIOD  = 2'd1,
    CFG_SECOND_DELAY  = 2'd2,
    CFG_SECOND_PERIOD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] first_delay;
    logic [CFG_W-1:0] first_period;
    logic [CFG_W-1:0] second_delay;
    logic [CFG_W-1:0] second_period;
  } cfg_t;

  typedef struct packed {
    logic [STAMP_W-1:0]      now_ms;
    logic                    new_touch;
    logic signed [VAL_W-1:0] button_value;
  } poll_t;

  typedef struct packed {
    logic                    fire;
    logic signed [VAL_W-1:0] value_out;
    phase_t                  phase;
  } result_t;

  // Saturating accumulate of an elapsed time into an accumulator
  function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] acc,
                                                    input logic [STAMP_W-1:0]    d);
    logic [SUM_W-1:0] s;
    s = SUM_W'(acc) + SUM_W'(d);
    if (|s[SUM_W-1:TIME_WIDTH]) begin
      return '1;
    end
    return s[TIME_WIDTH-1:0];
  endfunction

endpackage

@@ src/atr_cfg_regs.sv @@
// Configuration register file of the autorepeat timer: delays and periods.
// Depends on atr_pkg.
`timescale 1ns / 1ps

module atr_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [atr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [atr_pkg::CFG_W-1:0]   cfg_data,
  output atr_pkg::cfg_t               cfg
);
  import atr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIRST_DELAY:   cfg_nxt.first_delay   = cfg_data;
        CFG_FIRST_PERIOD:  cfg_nxt.first_period  = cfg_data;
        CFG_SECOND_DELAY:  cfg_nxt.second_delay  = cfg_data;
        CFG_SECOND_PERIOD: cfg_nxt.second_period = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ src/atr_step.sv @@
// Per-poll state update of the autorepeat timer: elapsed time, accumulators,
// phase and fire decision. Depends on atr_pkg.
`timescale 1ns / 1ps

module atr_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  atr_pkg::poll_t    poll,
  input  atr_pkg::cfg_t     cfg,
  output atr_pkg::result_t  result
);
  import atr_pkg::*;

  logic [STAMP_W-1:0]    last_poll_r, last_poll_nxt;
  logic [TIME_WIDTH-1:0] held_r, held_nxt;
  logic [TIME_WIDTH-1:0] since_fire_r, since_fire_nxt;
  phase_t                phase_r, phase_nxt;

  logic [STAMP_W-1:0]    elapsed;
  logic [TIME_WIDTH-1:0] held_sum;
  logic [TIME_WIDTH-1:0] since_sum;
  logic                  fire;

  // Elapsed time wraps with the timestamp
  assign elapsed   = poll.now_ms - last_poll_r;
  assign held_sum  = sat_add(held_r, elapsed);
  assign since_sum = sat_add(since_fire_r, elapsed);

  // Phase and fire decision
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_sum;
    fire      = 1'b0;
    if (poll.new_touch) begin
      phase_nxt = PH_START;
      held_nxt  = '0;
      fire      = 1'b1;
    end else if (held_sum > TIME_WIDTH'(cfg.second_delay)) begin
      phase_nxt = PH_SECOND;
      fire      = since_sum > TIME_WIDTH'(cfg.second_period);
    end else if (held_sum > TIME_WIDTH'(cfg.first_delay)) begin
      phase_nxt = PH_FIRST;
      fire      = since_sum > TIME_WIDTH'(cfg.first_period);
    end

    // A touch leaves the since-fire time alone, but it also fires and so clears it
    if (fire) begin
      since_fire_nxt = '0;
    end else begin
      since_fire_nxt = since_sum;
    end
    last_poll_nxt = poll.now_ms;
  end

  assign result.fire      = fire;
  assign result.value_out = poll.button_value;
  assign result.phase     = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_poll_r  <= '0;
      held_r       <= '0;
      since_fire_r <= '0;
      phase_r      <= PH_START;
    end else if (step_en) begin
      last_poll_r  <= last_poll_nxt;
      held_r       <= held_nxt;
      since_fire_r <= since_fire_nxt;
      phase_r      <= phase_nxt;
    end
  end

endmodule

@@ src/two_stage_autorepeat_timer.sv @@
// Top level of the two-stage autorepeat timer: stream ports, poll and result registers.
// Depends on atr_pkg, atr_cfg_regs, atr_step and the assertion macro header.
`timescale 1ns / 1ps

// Each input item is one poll of a held button; each poll gives exactly one result
// item. The block takes one poll per clock cycle while out_tready keeps the result
// register draining; a poll passes through the poll register, then the result register.
// The rate is set by the update of the held and since-fire accumulators, which every
// poll reads and writes. A full result register that is not taken stalls the poll
// register, and then in_tready drops. Configuration writes are taken in any cycle
// and belong in idle periods.

`include "two_stage_autorepeat_timer_macros.svh"

module two_stage_autorepeat_timer (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [atr_pkg::IN_TDATA_W-1:0]      in_tdata,   // now_ms[31:0], button_value[47:32]
  input  logic                                in_tuser,   // new_touch
  // result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [atr_pkg::OUT_TDATA_W-1:0]     out_tdata,  // value_out[15:0], phase[17:16], zero fill
  output logic                                out_tuser,  // fire
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [atr_pkg::IDX_W-1:0]           cfg_index,
  input  logic [atr_pkg::CFG_W-1:0]           cfg_data
);
  import atr_pkg::*;

  cfg_t    cfg;
  poll_t   poll_in;
  poll_t   poll_r;
  logic    poll_valid_r, poll_valid_nxt;
  result_t step_res;
  result_t res_r;
  logic    res_valid_r, res_valid_nxt;
  logic    advance;

  atr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the input item
  assign poll_in.now_ms       = in_tdata[STAMP_W-1:0];
  assign poll_in.new_touch    = in_tuser;
  assign poll_in.button_value = in_tdata[STAMP_W+VAL_W-1:STAMP_W];

  // Advance the held poll when the result register is free or being emptied
  assign advance   = poll_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !poll_valid_r || advance;

  atr_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .poll    (poll_r),
    .cfg     (cfg),
    .result  (step_res)
  );

  // Handshake bookkeeping for both registers
  always_comb begin
    poll_valid_nxt = poll_valid_r;
    if (in_tvalid && in_tready) begin
      poll_valid_nxt = 1'b1;
    end else if (advance) begin
      poll_valid_nxt = 1'b0;
    end

    res_valid_nxt = res_valid_r;
    if (advance) begin
      res_valid_nxt = 1'b1;
    end else if (out_tready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      poll_valid_r <= poll_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  // Payload registers: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      poll_r <= poll_in;
    end
    if (advance) begin
      res_r <= step_res;
    end
  end

  // Pack the result item
  assign out_tvalid = res_valid_r;
  assign out_tuser  = res_r.fire;
  assign out_tdata  = {{(OUT_TDATA_W-PHASE_W-VAL_W){1'b0}}, res_r.phase, res_r.value_out};

  // A touch always fires in its result
  `ATR_ASSERT_NEXT(a_touch_fires, advance && poll_r.new_touch, out_tvalid && out_tuser, "touch did not fire")
  // The phase only takes the start, first or second code
  `ATR_ASSERT_NOW(a_phase_legal, out_tvalid, (res_r.phase == PH_START) || (res_r.phase == PH_FIRST) || (res_r.phase == PH_SECOND), "illegal phase in result")
  // Input stalls only behind a held poll and a stalled result
  `ATR_ASSERT_NOW(a_stall_cause, !in_tready, poll_valid_r && res_valid_r && !out_tready, "input stalled without cause")
  // A taken result with nothing behind it leaves the output empty
  `ATR_ASSERT_NEXT(a_drain, out_tvalid && out_tready && !advance, !out_tvalid, "result repeated")

endmodule
